// ===== sv/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and constants shared by the four-function calculator core.
// ----------------------------------------------------------------------------
package ffc_pkg;

    localparam logic [2:0] KEY_DIGIT = 3'd0;
    localparam logic [2:0] KEY_ADD   = 3'd1;
    localparam logic [2:0] KEY_SUB   = 3'd2;
    localparam logic [2:0] KEY_MUL   = 3'd3;
    localparam logic [2:0] KEY_DIV   = 3'd4;
    localparam logic [2:0] KEY_EQU   = 3'd5;
    localparam logic [2:0] KEY_CLR   = 3'd6;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam int VALUE_W   = 64;
    localparam int ALU_CNT_W = 7;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_EQU  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        CMD_DIGIT,
        CMD_DIGIT_IGN,
        CMD_APPLY,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        t_op         op;
        logic [3:0]  digit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] digit_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] shown_value;
        logic                      shows_entry;
        logic                      entry_overflow;
        logic                      divide_by_zero;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        AL_IDLE,
        AL_MUL,
        AL_DIV,
        AL_DONE
    } t_alu_state;

    typedef enum logic {
        BK_IDLE,
        BK_WAIT
    } t_back_state;

endpackage

// ===== sv/ffc_front.sv =====
// ----------------------------------------------------------------------------
// ffc_front
// Classifies a key press into a command for the execution back end.
// ----------------------------------------------------------------------------
module ffc_front (
    input  ffc_pkg::t_in_item i_item,
    output ffc_pkg::t_cmd     o_cmd
);

    always_comb begin
        o_cmd.digit = i_item.digit_value;
        o_cmd.op    = ffc_pkg::OP_NONE;
        o_cmd.kind  = ffc_pkg::CMD_NOP;
        unique case (i_item.mode)
            ffc_pkg::KEY_DIGIT: begin
                if (i_item.digit_value <= ffc_pkg::DIGIT_MAX) begin
                    o_cmd.kind = ffc_pkg::CMD_DIGIT;
                end else begin
                    o_cmd.kind = ffc_pkg::CMD_DIGIT_IGN;
                end
            end
            ffc_pkg::KEY_ADD: begin
                o_cmd.kind = ffc_pkg::CMD_APPLY;
                o_cmd.op   = ffc_pkg::OP_ADD;
            end
            ffc_pkg::KEY_SUB: begin
                o_cmd.kind = ffc_pkg::CMD_APPLY;
                o_cmd.op   = ffc_pkg::OP_SUB;
            end
            ffc_pkg::KEY_MUL: begin
                o_cmd.kind = ffc_pkg::CMD_APPLY;
                o_cmd.op   = ffc_pkg::OP_MUL;
            end
            ffc_pkg::KEY_DIV: begin
                o_cmd.kind = ffc_pkg::CMD_APPLY;
                o_cmd.op   = ffc_pkg::OP_DIV;
            end
            ffc_pkg::KEY_EQU: begin
                o_cmd.kind = ffc_pkg::CMD_APPLY;
                o_cmd.op   = ffc_pkg::OP_EQU;
            end
            ffc_pkg::KEY_CLR: begin
                o_cmd.kind = ffc_pkg::CMD_CLEAR;
            end
            default: begin
                o_cmd.kind = ffc_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

// ===== sv/ffc_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ffc_cmd_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module ffc_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ffc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output ffc_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    ffc_pkg::t_cmd r_mem [0:1];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          n_wr;
    logic          n_rd;
    logic [1:0]    n_cnt;
    logic          w_wr_en;
    logic          w_rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr ^ w_wr_en;
        n_rd  = r_rd ^ w_rd_en;
        n_cnt = r_cnt + {1'b0, w_wr_en} - {1'b0, w_rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== sv/ffc_alu.sv =====
// ----------------------------------------------------------------------------
// ffc_alu
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ffc_alu #(
    parameter int ENTRY_W = 27
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffc_pkg::t_alu_req           i_req,
    input  logic [ffc_pkg::VALUE_W-1:0] i_a,
    input  logic [ENTRY_W-1:0]          i_b,
    output ffc_pkg::t_alu_rsp           o_rsp,
    output logic [ffc_pkg::VALUE_W-1:0] o_res
);

    localparam int VW = ffc_pkg::VALUE_W;
    localparam int CW = ffc_pkg::ALU_CNT_W;

    ffc_pkg::t_alu_state r_state;
    ffc_pkg::t_alu_state n_state;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic [VW-1:0]       r_a;
    logic [VW-1:0]       n_a;
    logic [ENTRY_W-1:0]  r_b;
    logic [ENTRY_W-1:0]  n_b;
    logic [VW-1:0]       r_acc;
    logic [VW-1:0]       n_acc;
    logic [ENTRY_W-1:0]  r_rem;
    logic [ENTRY_W-1:0]  n_rem;
    logic                r_neg;
    logic                n_neg;
    logic                r_div;
    logic                n_div;
    logic [ENTRY_W:0]    w_sh;
    logic [ENTRY_W:0]    w_diff;
    logic                w_ge;

    assign w_sh   = {r_rem, r_a[VW-1]};
    assign w_diff = w_sh - {1'b0, r_b};
    assign w_ge   = (w_sh >= {1'b0, r_b});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffc_pkg::AL_IDLE: begin
                if (i_req.start) begin
                    n_state = i_req.is_div ? ffc_pkg::AL_DIV : ffc_pkg::AL_MUL;
                end
            end
            ffc_pkg::AL_MUL, ffc_pkg::AL_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ffc_pkg::AL_DONE;
                end
            end
            ffc_pkg::AL_DONE: begin
                n_state = ffc_pkg::AL_IDLE;
            end
            default: begin
                n_state = ffc_pkg::AL_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        n_rem = r_rem;
        n_neg = r_neg;
        n_div = r_div;
        unique case (r_state)
            ffc_pkg::AL_IDLE: begin
                if (i_req.start) begin
                    n_div = i_req.is_div;
                    n_b   = i_b;
                    n_acc = '0;
                    n_rem = '0;
                    n_neg = i_a[VW-1];
                    if (i_req.is_div) begin
                        n_cnt = CW'(VW - 1);
                        n_a   = i_a[VW-1] ? (VW'(0) - i_a) : i_a;
                    end else begin
                        n_cnt = CW'(ENTRY_W - 1);
                        n_a   = i_a;
                    end
                end
            end
            ffc_pkg::AL_MUL: begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a   = {r_a[VW-2:0], 1'b0};
                n_b   = {1'b0, r_b[ENTRY_W-1:1]};
                n_cnt = r_cnt - CW'(1);
            end
            ffc_pkg::AL_DIV: begin
                n_rem = w_ge ? w_diff[ENTRY_W-1:0] : w_sh[ENTRY_W-1:0];
                n_a   = {r_a[VW-2:0], w_ge};
                n_cnt = r_cnt - CW'(1);
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffc_pkg::AL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_div <= n_div;
    end

    assign o_rsp.done = (r_state == ffc_pkg::AL_DONE);

    always_comb begin
        if (r_div) begin
            o_res = r_neg ? (VW'(0) - r_a) : r_a;
        end else begin
            o_res = r_acc;
        end
    end

endmodule

// ===== sv/ffc_back.sv =====
// ----------------------------------------------------------------------------
// ffc_back
// Execution back end: calculator state, command sequencing and result slot.
// ----------------------------------------------------------------------------
module ffc_back #(
    parameter int MAX_ENTRY_DIGITS = 8,
    parameter int ENTRY_W          = 27,
    parameter int CNT_W            = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffc_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    output ffc_pkg::t_out_item o_res,
    output logic               o_res_valid,
    input  logic               i_res_pop
);

    localparam int VW = ffc_pkg::VALUE_W;

    ffc_pkg::t_back_state r_state;
    ffc_pkg::t_back_state n_state;
    logic [VW-1:0]        r_run;
    logic [VW-1:0]        n_run;
    logic [ENTRY_W-1:0]   r_entry;
    logic [ENTRY_W-1:0]   n_entry;
    logic [CNT_W-1:0]     r_digits;
    logic [CNT_W-1:0]     n_digits;
    ffc_pkg::t_op         r_pending;
    ffc_pkg::t_op         n_pending;
    ffc_pkg::t_op         r_key;
    ffc_pkg::t_op         n_key;
    ffc_pkg::t_out_item   r_res;
    ffc_pkg::t_out_item   n_res;
    logic                 r_res_valid;
    logic                 n_res_valid;
    logic                 w_take;
    logic                 w_need_alu;
    logic [ENTRY_W+2:0]   w_e10;
    logic [VW-1:0]        w_entry_x;
    ffc_pkg::t_alu_req    w_alu_req;
    ffc_pkg::t_alu_rsp    w_alu_rsp;
    logic [VW-1:0]        w_alu_res;

    assign w_take     = (r_state == ffc_pkg::BK_IDLE) && i_cmd_valid && !r_res_valid;
    assign w_entry_x  = VW'(r_entry);
    assign w_e10      = {r_entry, 3'b000} + {2'b00, r_entry, 1'b0}
                      + (ENTRY_W + 3)'(i_cmd.digit);
    assign w_need_alu = (i_cmd.kind == ffc_pkg::CMD_APPLY)
                     && ((r_pending == ffc_pkg::OP_MUL)
                      || ((r_pending == ffc_pkg::OP_DIV) && (r_entry != '0)));

    assign w_alu_req.start  = w_take && w_need_alu;
    assign w_alu_req.is_div = (r_pending == ffc_pkg::OP_DIV);

    ffc_alu #(
        .ENTRY_W (ENTRY_W)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (r_run),
        .i_b     (r_entry),
        .o_rsp   (w_alu_rsp),
        .o_res   (w_alu_res)
    );

    assign o_cmd_pop   = w_take;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffc_pkg::BK_IDLE: begin
                if (w_take && w_need_alu) begin
                    n_state = ffc_pkg::BK_WAIT;
                end
            end
            ffc_pkg::BK_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_state = ffc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ffc_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_run       = r_run;
        n_entry     = r_entry;
        n_digits    = r_digits;
        n_pending   = r_pending;
        n_key       = r_key;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_pop;
        unique case (r_state)
            ffc_pkg::BK_IDLE: begin
                if (w_take) begin
                    n_res.shows_entry    = 1'b0;
                    n_res.entry_overflow = 1'b0;
                    n_res.divide_by_zero = 1'b0;
                    n_res_valid          = 1'b1;
                    unique case (i_cmd.kind)
                        ffc_pkg::CMD_DIGIT: begin
                            n_res.shows_entry = 1'b1;
                            if (r_digits < CNT_W'(MAX_ENTRY_DIGITS)) begin
                                n_entry  = w_e10[ENTRY_W-1:0];
                                n_digits = r_digits + CNT_W'(1);
                            end else begin
                                n_res.entry_overflow = 1'b1;
                            end
                            n_res.shown_value = VW'(n_entry);
                        end
                        ffc_pkg::CMD_DIGIT_IGN: begin
                            n_res.shows_entry = 1'b1;
                            n_res.shown_value = w_entry_x;
                        end
                        ffc_pkg::CMD_APPLY: begin
                            n_entry   = '0;
                            n_digits  = '0;
                            n_pending = i_cmd.op;
                            n_key     = i_cmd.op;
                            unique case (r_pending)
                                ffc_pkg::OP_ADD: n_run = r_run + w_entry_x;
                                ffc_pkg::OP_SUB: n_run = r_run - w_entry_x;
                                ffc_pkg::OP_MUL: n_res_valid = 1'b0;
                                ffc_pkg::OP_DIV: begin
                                    if (r_entry == '0) begin
                                        n_run                = '0;
                                        n_res.divide_by_zero = 1'b1;
                                    end else begin
                                        n_res_valid = 1'b0;
                                    end
                                end
                                ffc_pkg::OP_EQU: n_run = r_run;
                                default:         n_run = w_entry_x;
                            endcase
                            n_res.shown_value = n_run;
                        end
                        ffc_pkg::CMD_CLEAR: begin
                            n_run             = '0;
                            n_entry           = '0;
                            n_digits          = '0;
                            n_pending         = ffc_pkg::OP_NONE;
                            n_res.shown_value = '0;
                        end
                        default: begin
                            n_res.shown_value = r_run;
                        end
                    endcase
                end
            end
            ffc_pkg::BK_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_run                = w_alu_res;
                    n_pending            = r_key;
                    n_res.shown_value    = w_alu_res;
                    n_res.shows_entry    = 1'b0;
                    n_res.entry_overflow = 1'b0;
                    n_res.divide_by_zero = 1'b0;
                    n_res_valid          = 1'b1;
                end
            end
            default: begin
                n_res_valid = r_res_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffc_pkg::BK_IDLE;
            r_run       <= '0;
            r_entry     <= '0;
            r_digits    <= '0;
            r_pending   <= ffc_pkg::OP_NONE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_entry     <= n_entry;
            r_digits    <= n_digits;
            r_pending   <= n_pending;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
    end

`ifndef NO_ASSERTIONS
    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= CNT_W'(MAX_ENTRY_DIGITS))
        else $error("digit count beyond entry capacity");

    a_wait_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffc_pkg::BK_WAIT) |-> !r_res_valid)
        else $error("result slot busy while arithmetic unit runs");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> (r_state == ffc_pkg::BK_WAIT))
        else $error("arithmetic unit finished with no command waiting");

    a_wait_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ffc_pkg::BK_WAIT) && w_alu_rsp.done) |=> r_res_valid)
        else $error("finished multiply or divide left no result");
`endif

endmodule

// ===== sv/four_function_calculator_core.sv =====
// ----------------------------------------------------------------------------
// four_function_calculator_core
// Immediate-execution four-function calculator, one key press per item.
// Items with a multiply, or a divide by a non-zero entry, pending wait for the
// iterative arithmetic unit; all other items give their result without it.
// Throughput: one item in execution; the next starts once its result is popped.
// Synchronous reset clears all calculator state, the command queue and the result slot.
// ----------------------------------------------------------------------------
module four_function_calculator_core #(
    parameter int MAX_ENTRY_DIGITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ffc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output ffc_pkg::t_out_item o_result
);

    localparam logic [63:0] ENTRY_LIMIT = 64'(64'd10 ** MAX_ENTRY_DIGITS);
    localparam int          ENTRY_W     = $clog2(ENTRY_LIMIT);
    localparam int          CNT_W       = $clog2(MAX_ENTRY_DIGITS + 1);

    ffc_pkg::t_cmd w_front_cmd;
    ffc_pkg::t_cmd w_q_cmd;
    logic          w_q_empty;
    logic          w_q_pop;
    logic          w_res_valid;

    ffc_front u_front (
        .i_item (i_item),
        .o_cmd  (w_front_cmd)
    );

    ffc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd),
        .o_empty (w_q_empty)
    );

    ffc_back #(
        .MAX_ENTRY_DIGITS (MAX_ENTRY_DIGITS),
        .ENTRY_W          (ENTRY_W),
        .CNT_W            (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_cmd),
        .i_cmd_valid (!w_q_empty),
        .o_cmd_pop   (w_q_pop),
        .o_res       (o_result),
        .o_res_valid (w_res_valid),
        .i_res_pop   (pop)
    );

    assign empty = !w_res_valid;

endmodule

// ===== sim/four_function_calculator_core_test.sv =====
// ----------------------------------------------------------------------------
// four_function_calculator_core_test
// Self-checking testbench for the four-function calculator core. A directed
// key sequence covers entry overflow, ignored keys, every operator, negative
// division and divide by zero. Random key sequences follow, mostly numbers
// typed and closed by an operator. Results are predicted per accepted item
// and compared in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module four_function_calculator_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ENTRY_DIGITS  = 8;
    localparam int         RANDOM_KEYS   = 1350;
    localparam int         DRAIN_CYCLES  = 100;
    localparam logic [2:0] KEY_UNUSED    = 3'd7;
    localparam logic [3:0] DIGIT_TOP     = 4'd15;
    localparam int         REPORT_LIMIT  = 10;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push    = 1'b0;
    logic                pop     = 1'b0;
    logic                full;
    logic                empty;
    ffc_pkg::t_in_item   i_item  = '0;
    ffc_pkg::t_out_item  o_result;

    ffc_pkg::t_in_item   pending_keys[$];
    ffc_pkg::t_out_item  predicted_displays[$];
    int                  keys_total;
    int                  keys_accepted = 0;
    int                  displays_seen = 0;
    int                  mismatches = 0;

    logic [63:0]   calc_running;
    logic [63:0]   calc_entry;
    int unsigned   calc_digits;
    ffc_pkg::t_op  calc_pending;

    four_function_calculator_core #(
        .MAX_ENTRY_DIGITS(ENTRY_DIGITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void queue_key(input logic [2:0] mode, input logic [3:0] digit);
        ffc_pkg::t_in_item key;
        key.mode        = mode;
        key.digit_value = digit;
        pending_keys.push_back(key);
    endfunction

    // updates the calculator state and returns the expected display
    function automatic ffc_pkg::t_out_item press_key(input ffc_pkg::t_in_item key);
        ffc_pkg::t_out_item disp;
        logic               negative;
        logic [63:0]        magnitude;
        logic [63:0]        quotient;
        disp = '0;
        if (key.mode == ffc_pkg::KEY_DIGIT) begin
            disp.shows_entry = 1'b1;
            if (key.digit_value <= ffc_pkg::DIGIT_MAX) begin
                if (calc_digits < ENTRY_DIGITS) begin
                    calc_entry  = calc_entry * 64'd10 + 64'(key.digit_value);
                    calc_digits = calc_digits + 1;
                end else begin
                    disp.entry_overflow = 1'b1;
                end
            end
        end else if (key.mode >= ffc_pkg::KEY_ADD && key.mode <= ffc_pkg::KEY_EQU) begin
            case (calc_pending)
                ffc_pkg::OP_ADD: calc_running = calc_running + calc_entry;
                ffc_pkg::OP_SUB: calc_running = calc_running - calc_entry;
                ffc_pkg::OP_MUL: calc_running = calc_running * calc_entry;
                ffc_pkg::OP_DIV: begin
                    if (calc_entry == 64'd0) begin
                        calc_running        = '0;
                        disp.divide_by_zero = 1'b1;
                    end else begin
                        negative     = calc_running[63];
                        magnitude    = negative ? -calc_running : calc_running;
                        quotient     = magnitude / calc_entry;
                        calc_running = negative ? -quotient : quotient;
                    end
                end
                ffc_pkg::OP_EQU: ;
                default: calc_running = calc_entry;
            endcase
            calc_entry   = '0;
            calc_digits  = 0;
            calc_pending = ffc_pkg::t_op'(key.mode);
        end else if (key.mode == ffc_pkg::KEY_CLR) begin
            calc_running = '0;
            calc_entry   = '0;
            calc_digits  = 0;
            calc_pending = ffc_pkg::OP_NONE;
        end
        disp.shown_value = disp.shows_entry ? calc_entry : calc_running;
        return disp;
    endfunction

    function automatic int idle_share(input bit sender);
        if (keys_accepted < keys_total / 3) begin
            return sender ? 18 : 49;
        end else if (keys_accepted < 2 * keys_total / 3) begin
            return sender ? 49 : 18;
        end
        return 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push         <= 1'b0;
            calc_running = '0;
            calc_entry   = '0;
            calc_digits  = 0;
            calc_pending = ffc_pkg::OP_NONE;
        end else begin
            if (push && !full) begin
                predicted_displays.push_back(press_key(i_item));
                keys_accepted++;
            end
            if (!push || !full) begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= idle_share(1'b1)) begin
                    push   <= 1'b1;
                    i_item <= pending_keys.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ffc_pkg::t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                displays_seen++;
                if (predicted_displays.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected item %0d: value %0d", displays_seen,
                                 o_result.shown_value);
                    end
                end else begin
                    want = predicted_displays.pop_front();
                    if (o_result.shown_value    !== want.shown_value    ||
                        o_result.shows_entry    !== want.shows_entry    ||
                        o_result.entry_overflow !== want.entry_overflow ||
                        o_result.divide_by_zero !== want.divide_by_zero) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("mismatch on item %0d: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                                     displays_seen, want.shown_value, want.shows_entry,
                                     want.entry_overflow, want.divide_by_zero,
                                     o_result.shown_value, o_result.shows_entry,
                                     o_result.entry_overflow, o_result.divide_by_zero);
                        end
                    end
                end
            end
            pop <= ($urandom_range(99) >= idle_share(1'b0));
        end
    end

    initial begin
        int          roll;
        int          count;
        int          base;
        logic [2:0]  op;
        // directed: overflow, ignored keys, all operators, negative divide, divide by zero
        queue_key(ffc_pkg::KEY_CLR, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd7);
        queue_key(ffc_pkg::KEY_SUB, DIGIT_TOP);
        repeat (ENTRY_DIGITS) queue_key(ffc_pkg::KEY_DIGIT, ffc_pkg::DIGIT_MAX);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, DIGIT_TOP);
        queue_key(ffc_pkg::KEY_MUL, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd3);
        queue_key(ffc_pkg::KEY_DIV, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd5);
        queue_key(ffc_pkg::KEY_ADD, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd1);
        queue_key(ffc_pkg::KEY_EQU, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd4);
        queue_key(ffc_pkg::KEY_ADD, 4'd0);
        queue_key(KEY_UNUSED, DIGIT_TOP);
        queue_key(ffc_pkg::KEY_DIV, 4'd0);
        queue_key(ffc_pkg::KEY_EQU, 4'd0);
        queue_key(ffc_pkg::KEY_DIGIT, 4'd8);
        queue_key(ffc_pkg::KEY_CLR, DIGIT_TOP);
        // random: numbers typed and closed by an operator, with some noise
        base = pending_keys.size();
        while (pending_keys.size() < base + RANDOM_KEYS) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                queue_key(ffc_pkg::KEY_CLR, 4'($urandom_range(15)));
            end else if (roll < 7) begin
                queue_key(KEY_UNUSED, 4'($urandom_range(15)));
            end else if (roll < 10) begin
                queue_key(ffc_pkg::KEY_DIGIT, 4'($urandom_range(15, 10)));
            end else begin
                if ($urandom_range(9) == 0) begin
                    count = $urandom_range(ENTRY_DIGITS + 3, ENTRY_DIGITS + 1);
                end else begin
                    count = $urandom_range(ENTRY_DIGITS);
                end
                repeat (count) queue_key(ffc_pkg::KEY_DIGIT, 4'($urandom_range(9)));
                op = 3'($urandom_range(ffc_pkg::KEY_EQU, ffc_pkg::KEY_ADD));
                queue_key(op, 4'($urandom_range(15)));
            end
        end
        keys_total = pending_keys.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (keys_accepted == keys_total);
        while (predicted_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("four_function_calculator_core verification clean");
        end else begin
            $display("four_function_calculator_core verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("four_function_calculator_core verification failed");
        $finish;
    end

endmodule
